// ===== rtl/gptw_pkg.sv =====
// Shared types and constants for the guest page table walker.
package gptw_pkg;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAGING_MODE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_ROOT    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LARGE_PAGE_EN = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_PROTECT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NO_EXEC_EN    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMAP_EN       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMEP_EN       = 3'd6;

   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_LONG  = 2'd1;
   localparam logic [1:0] MODE_32BIT = 2'd2;
   localparam logic [1:0] MODE_PAE   = 2'd3;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_ENTRY = 1'b1;

   localparam logic RSP_READ = 1'b0;
   localparam logic RSP_DONE = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [63:0] virt_addr;
      logic        access_write;
      logic        access_fetch;
      logic        access_user;
      logic        align_check;
      logic [63:0] entry_data;
      logic        entry_mapped;
   } gptw_req_type;

   typedef struct packed {
      logic        out_kind;
      logic [51:0] read_addr;
      logic        read_narrow;
      logic [63:0] phys_addr;
      logic        fault;
      logic        err_present;
      logic        err_user;
   } gptw_rsp_type;

endpackage

// ===== rtl/guest_page_table_walker.sv =====
// Guest page table walker: top level, walk control and result buffering.
// A result is registered into the output register, or into the skid register while rsp stalls.
// Throughput: one input transfer per cycle while req_stall is low; each entry reply is one level.
// req_stall rises only while the output register and the skid register are both full.
// Synchronous reset idles the walk, drops buffered results, clears the CSR registers to 0.
module guest_page_table_walker
   import gptw_pkg::*;
#(
   parameter int unsigned PHYS_ADDR_BITS = 52
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  gptw_req_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output gptw_rsp_type              rsp_data
);

   localparam int unsigned FRAME_BITS = PHYS_ADDR_BITS - 12;

   logic [1:0]                mode_ff;
   logic [PHYS_ADDR_BITS-1:5] root_ff;
   logic                      pse_ff, wp_ff, nxe_ff, smap_ff, smep_ff;

   logic                  busy_ff, busy_in;
   logic [2:0]            levels_ff, levels_in;
   logic                  pdpt_ff, pdpt_in;
   logic [63:0]           vaddr_ff, vaddr_in;
   logic [3:0]            flags_ff, flags_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic                  ups_ff, ups_in;
   logic                  aw_ff, aw_in;

   gptw_rsp_type rsp_ff, skid_ff;
   logic         rsp_valid_ff, skid_valid_ff;

   logic         accept, push;
   gptw_rsp_type res;

   logic        nar, pse, nxe, wr, fe, us, ac;
   logic [63:0] ent;
   logic [1:0]  lvl_i;
   logic        f_a, f_b, f_c, f_d, aw_n, ups_n, big_page, descend, smap_f, smep_f;
   logic [63:0] low_mask;

   function automatic logic [5:0] level_shift(input logic [1:0] lvl, input logic narrow);
      logic [5:0] sh;
      case (lvl)
         2'd0:    sh = 6'd12;
         2'd1:    sh = narrow ? 6'd22 : 6'd21;
         2'd2:    sh = narrow ? 6'd32 : 6'd30;
         default: sh = narrow ? 6'd42 : 6'd39;
      endcase
      return sh;
   endfunction

   function automatic logic [51:0] level_addr(input logic [FRAME_BITS-1:0] frame,
                                              input logic [63:0] va,
                                              input logic [1:0] lvl,
                                              input logic narrow);
      logic [63:0] s;
      logic [9:0]  idx;
      logic [12:0] off;
      s   = va >> level_shift(lvl, narrow);
      idx = narrow ? s[9:0] : {1'b0, s[8:0]};
      off = narrow ? {1'b0, idx, 2'b00} : {idx, 3'b000};
      return 52'({frame, 12'h000}) + 52'(off);
   endfunction

   assign accept    = req_valid & ~req_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // entry checks for a reply below the PDPT
   always_comb begin
      nar   = (mode_ff == MODE_32BIT);
      pse   = nar ? pse_ff : 1'b1;
      nxe   = ~nar & nxe_ff;
      wr    = flags_ff[0];
      fe    = flags_ff[1];
      us    = flags_ff[2];
      ac    = flags_ff[3];
      ent   = nar ? {32'h0, req_data.entry_data[31:0]} : req_data.entry_data;
      lvl_i = (levels_ff == 3'd0) ? 2'd0 : 2'(levels_ff - 3'd1);
      f_a   = ~req_data.entry_mapped | ~ent[0];
      aw_n  = (~f_a & ~ent[1]) ? 1'b0 : aw_ff;
      f_b   = f_a | (~ent[1] & wr & (us | wp_ff));
      f_c   = f_b | (fe & nxe & ent[63]);
      ups_n = (~f_c & ~ent[2]) ? 1'b0 : ups_ff;
      f_d   = f_c | (~ent[2] & us);
      big_page = pse & (lvl_i != 2'd0) & ent[7];
      descend = ~f_d & ~big_page & (lvl_i != 2'd0);
      smap_f = smap_ff & ~us & ups_n & (wr ? (~ac | (wp_ff & ~aw_n)) : ~ac);
      smep_f = smep_ff & ~us & ups_n & fe;
      low_mask = (64'd1 << level_shift(lvl_i, nar)) - 64'd1;
   end

   always_comb begin
      busy_in   = busy_ff;
      levels_in = levels_ff;
      pdpt_in   = pdpt_ff;
      vaddr_in  = vaddr_ff;
      flags_in  = flags_ff;
      frame_in  = frame_ff;
      ups_in    = ups_ff;
      aw_in     = aw_ff;
      push      = 1'b0;
      res       = '0;
      if (accept) begin
         if (req_data.req_type == REQ_START) begin
            if (!busy_ff) begin
               push     = 1'b1;
               vaddr_in = req_data.virt_addr;
               flags_in = {req_data.align_check, req_data.access_user,
                           req_data.access_fetch, req_data.access_write};
               ups_in   = 1'b1;
               aw_in    = 1'b1;
               pdpt_in  = 1'b0;
               if (mode_ff == MODE_OFF) begin
                  levels_in     = 3'd0;
                  res.out_kind  = RSP_DONE;
                  res.phys_addr = req_data.virt_addr;
               end else if (mode_ff == MODE_PAE) begin
                  busy_in       = 1'b1;
                  pdpt_in       = 1'b1;
                  levels_in     = 3'd0;
                  res.out_kind  = RSP_READ;
                  res.read_addr = {20'h0, root_ff[31:5], req_data.virt_addr[31:30], 3'b000};
               end else begin
                  busy_in         = 1'b1;
                  frame_in        = root_ff[PHYS_ADDR_BITS-1:12];
                  levels_in       = (mode_ff == MODE_LONG) ? 3'd4 : 3'd2;
                  res.out_kind    = RSP_READ;
                  res.read_narrow = nar;
                  res.read_addr   = level_addr(root_ff[PHYS_ADDR_BITS-1:12],
                                               req_data.virt_addr,
                                               (mode_ff == MODE_LONG) ? 2'd3 : 2'd1, nar);
               end
            end
         end else if (busy_ff) begin
            push = 1'b1;
            if (pdpt_ff) begin
               if (!req_data.entry_mapped || !req_data.entry_data[0]) begin
                  busy_in      = 1'b0;
                  pdpt_in      = 1'b0;
                  levels_in    = 3'd0;
                  res.out_kind = RSP_DONE;
                  res.fault    = 1'b1;
                  res.err_user = flags_ff[2];
               end else begin
                  pdpt_in         = 1'b0;
                  frame_in        = req_data.entry_data[PHYS_ADDR_BITS-1:12];
                  levels_in       = 3'd2;
                  res.out_kind    = RSP_READ;
                  res.read_narrow = nar;
                  res.read_addr   = level_addr(req_data.entry_data[PHYS_ADDR_BITS-1:12],
                                               vaddr_ff, 2'd1, nar);
               end
            end else begin
               aw_in  = aw_n;
               ups_in = ups_n;
               if (descend) begin
                  frame_in        = ent[PHYS_ADDR_BITS-1:12];
                  levels_in       = {1'b0, lvl_i};
                  res.out_kind    = RSP_READ;
                  res.read_narrow = nar;
                  res.read_addr   = level_addr(ent[PHYS_ADDR_BITS-1:12], vaddr_ff,
                                               lvl_i - 2'd1, nar);
               end else begin
                  busy_in      = 1'b0;
                  pdpt_in      = 1'b0;
                  levels_in    = 3'd0;
                  res.out_kind = RSP_DONE;
                  if (f_d || smap_f || smep_f) begin
                     res.fault       = 1'b1;
                     res.err_present = 1'b1;
                     res.err_user    = us;
                  end else begin
                     res.phys_addr = ({12'h0, ent[51:0]} & ~low_mask) | (vaddr_ff & low_mask);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OFF;
         root_ff  <= '0;
         pse_ff   <= 1'b0;
         wp_ff    <= 1'b0;
         nxe_ff   <= 1'b0;
         smap_ff  <= 1'b0;
         smep_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAGING_MODE:   mode_ff <= csr_wdata[1:0];
            CSR_TABLE_ROOT:    root_ff <= csr_wdata[PHYS_ADDR_BITS-1:5];
            CSR_LARGE_PAGE_EN: pse_ff  <= csr_wdata[0];
            CSR_WRITE_PROTECT: wp_ff   <= csr_wdata[0];
            CSR_NO_EXEC_EN:    nxe_ff  <= csr_wdata[0];
            CSR_SMAP_EN:       smap_ff <= csr_wdata[0];
            CSR_SMEP_EN:       smep_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         levels_ff <= 3'd0;
         pdpt_ff   <= 1'b0;
         vaddr_ff  <= '0;
         flags_ff  <= '0;
         frame_ff  <= '0;
         ups_ff    <= 1'b1;
         aw_ff     <= 1'b1;
      end else begin
         busy_ff   <= busy_in;
         levels_ff <= levels_in;
         pdpt_ff   <= pdpt_in;
         vaddr_ff  <= vaddr_in;
         flags_ff  <= flags_in;
         frame_ff  <= frame_in;
         ups_ff    <= ups_in;
         aw_ff     <= aw_in;
      end
   end

   // output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_ff <= skid_valid_ff ? skid_ff : res;
      end else if (push) begin
         skid_ff <= res;
      end
   end

   a_skid_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff) else $error("skid holds data with output empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> rsp_valid_ff) else $error("result lost from skid");

   a_pdpt_busy: assert property (@(posedge clock) disable iff (reset)
      pdpt_ff |-> busy_ff) else $error("PDPT phase while idle");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (levels_ff == 3'd0)) else $error("levels left while idle");

   a_levels_range: assert property (@(posedge clock) disable iff (reset)
      levels_ff <= 3'd4) else $error("level count out of range");

endmodule

// ===== verif/tb.sv =====
// Testbench for guest_page_table_walker: walk-aware stimulus with a predicting scoreboard.
`timescale 1ns / 1ps

module tb;
   import gptw_pkg::*;

   localparam int ENTRY_P   = 0;
   localparam int ENTRY_RW  = 1;
   localparam int ENTRY_US  = 2;
   localparam int ENTRY_PS  = 7;
   localparam int ENTRY_XD  = 63;
   localparam int ACC_WRITE = 0;
   localparam int ACC_FETCH = 1;
   localparam int ACC_USER  = 2;
   localparam int ACC_AC    = 3;

   localparam logic [63:0] PAGE_MASK   = 64'h000F_FFFF_FFFF_F000;
   localparam logic [63:0] ADDR52_MASK = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] PDPT_MASK   = 64'h0000_0000_FFFF_FFE0;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 250;
   localparam int BLOCK_ITEMS = 50;

   class walk_scoreboard;
      logic [1:0]   mode;
      logic [63:0]  root;
      logic         pse_en, wp_en, nxe_en, smap_on, smep_on;
      bit           busy;
      logic [2:0]   levels_left;
      bit           in_pdpt;
      logic [63:0]  vaddr;
      logic [3:0]   acc_flags;
      logic [51:0]  table_base;
      bit           user_seen, all_writable;
      gptw_rsp_type due_results[$];
      int           mismatches;

      function new();
         mode = MODE_OFF;
         root = '0;
         pse_en = 1'b0;
         wp_en = 1'b0;
         nxe_en = 1'b0;
         smap_on = 1'b0;
         smep_on = 1'b0;
         busy = 1'b0;
         levels_left = '0;
         in_pdpt = 1'b0;
         vaddr = '0;
         acc_flags = '0;
         table_base = '0;
         user_seen = 1'b1;
         all_writable = 1'b1;
         mismatches = 0;
      endfunction

      function void write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_PAGING_MODE:   mode = data[1:0];
            CSR_TABLE_ROOT:    root = data;
            CSR_LARGE_PAGE_EN: pse_en = data[0];
            CSR_WRITE_PROTECT: wp_en = data[0];
            CSR_NO_EXEC_EN:    nxe_en = data[0];
            CSR_SMAP_EN:       smap_on = data[0];
            CSR_SMEP_EN:       smep_on = data[0];
            default: ;
         endcase
      endfunction

      function void issue_read(logic [63:0] addr, bit narrow);
         gptw_rsp_type r;
         r = '0;
         r.out_kind = RSP_READ;
         r.read_addr = addr[51:0];
         r.read_narrow = narrow;
         due_results.push_back(r);
      endfunction

      function void finish_walk(logic [63:0] phys, bit flt, bit p);
         gptw_rsp_type r;
         r = '0;
         r.out_kind = RSP_DONE;
         r.phys_addr = flt ? 64'd0 : phys;
         r.fault = flt;
         r.err_present = flt && p;
         r.err_user = flt && acc_flags[ACC_USER];
         due_results.push_back(r);
         busy = 1'b0;
         in_pdpt = 1'b0;
         levels_left = '0;
      endfunction

      function void request_level(int lvl);
         int w, sh;
         logic [63:0] idx, base;
         bit narrow;
         w = (mode == MODE_32BIT) ? 10 : 9;
         sh = lvl * w + 12;
         idx = (vaddr >> sh) & ((64'd1 << w) - 64'd1);
         base = {12'd0, table_base} & PAGE_MASK;
         narrow = (w == 10);
         levels_left = 3'(lvl + 1);
         issue_read(base + idx * (narrow ? 64'd4 : 64'd8), narrow);
      endfunction

      function void walk_entry(logic [63:0] raw, logic mapped);
         int w, lvl, sh, ll;
         bit narrow, pse, nxe, wr, fe, us, ac, flt, big_page;
         logic [63:0] e, low_mask, phys, tmp;
         w = (mode == MODE_32BIT) ? 10 : 9;
         narrow = (w == 10);
         pse = narrow ? pse_en : 1'b1;
         nxe = narrow ? 1'b0 : nxe_en;
         wr = acc_flags[ACC_WRITE];
         fe = acc_flags[ACC_FETCH];
         us = acc_flags[ACC_USER];
         ac = acc_flags[ACC_AC];
         ll = int'(levels_left);
         lvl = (ll == 0) ? 0 : ((ll - 1) & 3);
         sh = lvl * w + 12;
         e = narrow ? {32'd0, raw[31:0]} : raw;
         flt = 1'b0;
         big_page = 1'b0;
         if (!mapped) begin
            flt = 1'b1;
         end else begin
            if (!e[ENTRY_P]) flt = 1'b1;
            if (!flt && !e[ENTRY_RW]) begin
               if (wr && (us || wp_en)) flt = 1'b1;
               all_writable = 1'b0;
            end
         end
         if (!flt && fe && nxe && e[ENTRY_XD]) flt = 1'b1;
         if (!flt && !e[ENTRY_US]) begin
            user_seen = 1'b0;
            if (us) flt = 1'b1;
         end
         if (flt) begin
            finish_walk(64'd0, 1'b1, 1'b1);
            return;
         end
         if (pse && lvl > 0 && e[ENTRY_PS]) big_page = 1'b1;
         if (!big_page && lvl > 0) begin
            tmp = e & PAGE_MASK;
            table_base = tmp[51:0];
            request_level(lvl - 1);
            return;
         end
         if (smap_on && !us && user_seen) begin
            if (!wr) begin
               if (!ac) flt = 1'b1;
            end else if (!ac || (wp_en && !all_writable)) begin
               flt = 1'b1;
            end
         end
         if (!flt && smep_on && !us && user_seen && fe) flt = 1'b1;
         if (flt) begin
            finish_walk(64'd0, 1'b1, 1'b1);
            return;
         end
         low_mask = (64'd1 << sh) - 64'd1;
         phys = (e & ADDR52_MASK & ~low_mask) | (vaddr & low_mask);
         finish_walk(phys, 1'b0, 1'b0);
      endfunction

      // returns 1 when the transfer took effect, 0 when it was out of turn
      function bit advance_walk(gptw_req_type req);
         logic [63:0] tmp;
         if (req.req_type == REQ_START) begin
            if (busy) return 1'b0;
            vaddr = req.virt_addr;
            acc_flags = {req.align_check, req.access_user, req.access_fetch, req.access_write};
            user_seen = 1'b1;
            all_writable = 1'b1;
            in_pdpt = 1'b0;
            if (mode == MODE_OFF) begin
               finish_walk(vaddr, 1'b0, 1'b0);
               return 1'b1;
            end
            busy = 1'b1;
            if (mode == MODE_PAE) begin
               in_pdpt = 1'b1;
               levels_left = '0;
               issue_read((root & PDPT_MASK) + ((vaddr >> 30) & 64'd3) * 64'd8, 1'b0);
               return 1'b1;
            end
            table_base = root[51:0];
            request_level((mode == MODE_LONG) ? 3 : 1);
            return 1'b1;
         end
         if (!busy) return 1'b0;
         if (in_pdpt) begin
            if (!req.entry_mapped || !req.entry_data[ENTRY_P]) begin
               finish_walk(64'd0, 1'b1, 1'b0);
            end else begin
               in_pdpt = 1'b0;
               tmp = req.entry_data & PAGE_MASK;
               table_base = tmp[51:0];
               request_level(1);
            end
            return 1'b1;
         end
         walk_entry(req.entry_data, req.entry_mapped);
         return 1'b1;
      endfunction

      function string describe(gptw_rsp_type r);
         return $sformatf("kind=%0d read_addr=%h narrow=%0d phys=%h fault=%0d p=%0d us=%0d",
                          r.out_kind, r.read_addr, r.read_narrow, r.phys_addr, r.fault,
                          r.err_present, r.err_user);
      endfunction

      function void check_result(gptw_rsp_type got);
         gptw_rsp_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %s", describe(got));
            return;
         end
         want = due_results.pop_front();
         if (got.out_kind !== want.out_kind || got.read_addr !== want.read_addr ||
             got.read_narrow !== want.read_narrow || got.phys_addr !== want.phys_addr ||
             got.fault !== want.fault || got.err_present !== want.err_present ||
             got.err_user !== want.err_user) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result mismatch at %0t", $realtime);
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   gptw_req_type              req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   gptw_rsp_type              rsp_data;

   walk_scoreboard sb;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int items_done = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   guest_page_table_walker dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: random stall, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic gptw_req_type start_item(logic [63:0] va, bit wr, bit fe, bit us, bit ac);
      gptw_req_type it;
      it = '0;
      it.req_type = REQ_START;
      it.virt_addr = va;
      it.access_write = wr;
      it.access_fetch = fe;
      it.access_user = us;
      it.align_check = ac;
      return it;
   endfunction

   function automatic gptw_req_type entry_item(logic [63:0] data, bit mapped);
      gptw_req_type it;
      it = '0;
      it.req_type = REQ_ENTRY;
      it.entry_data = data;
      it.entry_mapped = mapped;
      return it;
   endfunction

   function automatic logic [63:0] make_entry(logic [63:0] frame, bit p, bit rw, bit us, bit ps,
                                              bit xd);
      logic [63:0] e;
      e = frame;
      e[ENTRY_P] = p;
      e[ENTRY_RW] = rw;
      e[ENTRY_US] = us;
      e[ENTRY_PS] = ps;
      e[ENTRY_XD] = xd;
      return e;
   endfunction

   // mostly well-formed walks with random content; some noise and out-of-turn items
   function automatic gptw_req_type next_walk_item();
      gptw_req_type it;
      it.virt_addr = {$urandom, $urandom};
      case ($urandom_range(9))
         0: it.virt_addr = '1;
         1: it.virt_addr = '0;
         default: ;
      endcase
      it.access_write = 1'($urandom_range(1));
      it.access_fetch = ($urandom_range(99) < 30);
      it.access_user = 1'($urandom_range(1));
      it.align_check = 1'($urandom_range(1));
      it.entry_data = {$urandom, $urandom};
      it.entry_mapped = ($urandom_range(99) < 95);
      if (!sb.busy) begin
         it.req_type = ($urandom_range(99) < 5) ? REQ_ENTRY : REQ_START;
      end else begin
         it.req_type = ($urandom_range(99) < 3) ? REQ_START : REQ_ENTRY;
      end
      if ($urandom_range(99) < 90) begin
         it.entry_data[ENTRY_P] = ($urandom_range(99) < 92);
         it.entry_data[ENTRY_RW] = ($urandom_range(99) < 75);
         it.entry_data[ENTRY_US] = sb.acc_flags[ACC_USER] ? ($urandom_range(99) < 90)
                                                          : ($urandom_range(99) < 50);
         it.entry_data[ENTRY_PS] = ($urandom_range(99) < 20);
         it.entry_data[ENTRY_XD] = ($urandom_range(99) < 15);
      end
      return it;
   endfunction

   task automatic send_item(input gptw_req_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      if (sb.advance_walk(it)) items_done++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic close_walk();
      gptw_req_type it;
      while (sb.busy) begin
         it = next_walk_item();
         it.req_type = REQ_ENTRY;
         send_item(it);
      end
      settle();
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_csr(index, data);
   endtask

   task automatic apply_config(input logic [63:0] mode_v, root_v, pse_v, wp_v, nxe_v, smap_v,
                               smep_v);
      write_reg(CSR_PAGING_MODE, mode_v);
      write_reg(CSR_TABLE_ROOT, root_v);
      write_reg(CSR_LARGE_PAGE_EN, pse_v);
      write_reg(CSR_WRITE_PROTECT, wp_v);
      write_reg(CSR_NO_EXEC_EN, nxe_v);
      write_reg(CSR_SMAP_EN, smap_v);
      write_reg(CSR_SMEP_EN, smep_v);
      csr_we <= 1'b0;
   endtask

   task automatic random_config();
      logic [63:0] mode_v, root_v;
      mode_v = 64'($urandom_range(1, 3));
      if ($urandom_range(7) == 0) mode_v = 64'(MODE_OFF);
      case ($urandom_range(3))
         0: root_v = '0;
         1: root_v = '1;
         default: root_v = {$urandom, $urandom};
      endcase
      apply_config(mode_v, root_v, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   task automatic run_directed();
      // paging off, out-of-turn reply, address extremes
      send_item(entry_item('1, 1'b1));
      send_item(start_item('1, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(start_item('0, 1'b0, 1'b0, 1'b0, 1'b0));
      settle();
      // 4-level: start while busy, 2M page through SMAP with AC, then NX fault
      apply_config(64'(MODE_LONG), '1, 64'd0, 64'd1, 64'd1, 64'd1, 64'd1);
      send_item(start_item('1, 1'b1, 1'b0, 1'b0, 1'b1));
      send_item(start_item('0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(entry_item(make_entry(PAGE_MASK, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 1'b1));
      send_item(entry_item(make_entry(64'h0000_0123_4567_8000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0),
                           1'b1));
      send_item(entry_item(make_entry(64'h000A_BCDE_F020_0000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0),
                           1'b1));
      send_item(start_item(64'h0000_7FFF_FFFF_F000, 1'b0, 1'b1, 1'b0, 1'b0));
      send_item(entry_item(make_entry(64'h0000_0000_0010_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1),
                           1'b1));
      settle();
      // PAE: PDPT unmapped, read-only user write, PDPT not present
      apply_config(64'(MODE_PAE), '0, 64'd0, 64'd1, 64'd0, 64'd0, 64'd0);
      send_item(start_item('1, 1'b1, 1'b0, 1'b1, 1'b0));
      send_item(entry_item(make_entry(64'h0000_0000_0020_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0),
                           1'b0));
      send_item(start_item(64'h0000_0000_4000_0000, 1'b1, 1'b0, 1'b1, 1'b0));
      send_item(entry_item(make_entry(64'h0000_0000_0030_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0),
                           1'b1));
      send_item(entry_item(make_entry(64'h0000_0000_0040_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0),
                           1'b1));
      send_item(start_item(64'h0000_0000_C000_0000, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(entry_item(64'd0, 1'b1));
      settle();
      // 32-bit: narrow 4M page, not present, SMAP write, SMEP fetch
      apply_config(64'(MODE_32BIT), {$urandom, $urandom}, 64'd1, 64'd0, 64'd1, 64'd1, 64'd1);
      send_item(start_item(64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_item(entry_item(64'hFFFF_FFFF_FFFF_FF83, 1'b1));
      send_item(start_item(64'h0000_0000_0040_1000, 1'b0, 1'b0, 1'b1, 1'b0));
      send_item(entry_item(64'd0, 1'b1));
      send_item(start_item(64'h0000_0000_0080_2000, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(entry_item(make_entry(64'h0000_0000_0050_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0),
                           1'b1));
      send_item(entry_item(make_entry(64'h0000_0000_0060_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0),
                           1'b1));
      send_item(start_item(64'h0000_0000_00C0_3000, 1'b0, 1'b1, 1'b0, 1'b1));
      send_item(entry_item(make_entry(64'h0000_0000_0070_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0),
                           1'b1));
      send_item(entry_item(make_entry(64'h0000_0000_0080_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0),
                           1'b1));
      close_walk();
   endtask

   initial begin
      int base_count;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 61;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 61;
            end
            default: begin
               send_idle_pct = 14;
               stall_pct = 14;
            end
         endcase
         for (int blk = 0; blk < 4; blk++) begin
            random_config();
            // long receiver hold-off while the sender keeps streaming
            if (ph == 0 && blk == 1) hold_requests++;
            base_count = items_done;
            while (items_done - base_count < BLOCK_ITEMS) send_item(next_walk_item());
            close_walk();
         end
      end
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/gptw_pkg.sv
rtl/guest_page_table_walker.sv
verif/tb.sv
